@@ src/three_level_exclusive_cache_lru_defines.svh @@
// Assertion macros for the cache RTL.
`ifndef THREE_LEVEL_EXCLUSIVE_CACHE_LRU_DEFINES_SVH
`define THREE_LEVEL_EXCLUSIVE_CACHE_LRU_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache check failed");

`endif

@@ src/tlc_pkg.sv @@
// Types and constants shared by the three-level exclusive cache.
package tlc_pkg;

  localparam int BlkW      = 10;
  localparam int CostW     = 20;
  localparam int AgeW      = 32;
  localparam int MemBlocks = 1024;

  typedef struct packed {
    logic [BlkW-1:0] block_address;
    logic            is_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       hit_level;
    logic [2:0]       level_one_slot;
    logic [CostW-1:0] access_cost;
    logic             writeback_valid;
    logic [BlkW-1:0]  writeback_block;
  } out_item_t;

  // One cache slot: block tag with its dirty bit and age.
  typedef struct packed {
    logic            valid;
    logic [BlkW-1:0] blk;
    logic            dirty;
    logic [AgeW-1:0] age;
  } ent_t;

  localparam logic [1:0] LVL_ONE   = 2'd0;
  localparam logic [1:0] LVL_TWO   = 2'd1;
  localparam logic [1:0] LVL_THREE = 2'd2;
  localparam logic [1:0] LVL_MEM   = 2'd3;

  localparam logic [1:0] CFG_COST_L1  = 2'd0;
  localparam logic [1:0] CFG_COST_L2  = 2'd1;
  localparam logic [1:0] CFG_COST_L3  = 2'd2;
  localparam logic [1:0] CFG_COST_MEM = 2'd3;

endpackage

@@ src/tlc_store.sv @@
// Slot memory for all three levels with per-slot valid flags.
module tlc_store
  import tlc_pkg::*;
#(
  parameter int DEPTH = 56,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output ent_t          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  ent_t          wr_data
);

  ent_t             mem [DEPTH];
  ent_t             rd_q_r;
  logic             vld_q_r;
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= wr_data.valid;
      end
    end
  end

  // A slot never written since reset reads as an empty slot.
  assign rd_data = vld_q_r ? rd_q_r : '0;

endmodule

@@ src/three_level_exclusive_cache_lru.sv @@
// Three fully associative, mutually exclusive cache levels with LRU replacement
// and write-back reporting. All slots of the three levels share one memory
// (level one first, then two, then three). For each item, one pass reads every
// slot through the single memory read port to find the block and each level's
// victim, then one to three writes through the single write port move blocks
// between levels, then the result is registered. Items are handled one at a time,
// so reads and writes to the same slot never overlap. Reset clears the valid
// flags at once; no clearing pass is needed.
module three_level_exclusive_cache_lru
  import tlc_pkg::*;
#(
  parameter int L1_SLOTS = 8,
  parameter int L2_SLOTS = 16,
  parameter int L3_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [CostW-1:0] cfg_data
);

`include "three_level_exclusive_cache_lru_defines.svh"

  localparam int Depth  = L1_SLOTS + L2_SLOTS + L3_SLOTS;
  localparam int AW     = $clog2(Depth);
  localparam int L2Base = L1_SLOTS;
  localparam int L3Base = L1_SLOTS + L2_SLOTS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WR   = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t           state_r;
  logic [CostW-1:0] cost_r [4];
  logic [AgeW-1:0]  clk_cnt_r;
  logic [BlkW-1:0]  blk_r;
  logic             wr_r;
  logic [AW:0]      rd_cnt_r;
  logic             chk_vld_r;
  logic [AW-1:0]    chk_addr_r;
  logic [1:0]       step_r;

  logic             found_r [3];
  logic [AW-1:0]    fpos_r  [3];
  ent_t             fent_r  [3];
  logic [AW-1:0]    vpos_r  [3];
  ent_t             vent_r  [3];
  logic             vinv_r  [3];

  out_item_t        res_r;
  out_item_t        out_data_r;
  logic             out_valid_r;

  ent_t             rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  ent_t             wr_data;

  logic             in_acc;
  logic [1:0]       lv;
  logic             lv_first;
  logic             match;
  logic             take_vic;
  logic [1:0]       hit_lvl;
  ent_t             up_ent;
  logic [AW-1:0]    h1_addr;
  logic [AW-1:0]    s3_addr;
  logic [1:0]       last_step;
  out_item_t        res_nxt;

  tlc_store #(.DEPTH(Depth), .AW(AW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_addr   = rd_cnt_r[AW-1:0];

  // Scan bookkeeping for the slot whose data arrives this cycle.
  always_comb begin
    if (chk_addr_r < AW'(L2Base)) begin
      lv = LVL_ONE;
    end else if (chk_addr_r < AW'(L3Base)) begin
      lv = LVL_TWO;
    end else begin
      lv = LVL_THREE;
    end
    lv_first = (chk_addr_r == '0) || (chk_addr_r == AW'(L2Base)) ||
               (chk_addr_r == AW'(L3Base));
    match    = rd_data.valid && (rd_data.blk == blk_r);
    // First invalid slot wins; otherwise the first slot of the smallest age.
    take_vic = lv_first || (!vinv_r[lv] && (!rd_data.valid || rd_data.age < vent_r[lv].age));
  end

  // Block moves once the scan is complete.
  always_comb begin
    if (found_r[0]) begin
      hit_lvl = LVL_ONE;
    end else if (found_r[1]) begin
      hit_lvl = LVL_TWO;
    end else if (found_r[2]) begin
      hit_lvl = LVL_THREE;
    end else begin
      hit_lvl = LVL_MEM;
    end

    case (hit_lvl)
      LVL_ONE:   up_ent = fent_r[0];
      LVL_TWO:   up_ent = fent_r[1];
      LVL_THREE: up_ent = fent_r[2];
      default: begin
        up_ent       = '0;
        up_ent.valid = 1'b1;
        up_ent.blk   = blk_r;
      end
    endcase
    up_ent.age   = clk_cnt_r;
    up_ent.dirty = up_ent.dirty | wr_r;

    h1_addr = (hit_lvl == LVL_ONE) ? fpos_r[0] : vpos_r[0];
    s3_addr = (hit_lvl == LVL_THREE) ? fpos_r[2] : vpos_r[2];

    case (hit_lvl)
      LVL_ONE: last_step = 2'd0;
      LVL_TWO: last_step = 2'd1;
      default: last_step = 2'd2;
    endcase

    wr_en   = (state_r == ST_WR);
    wr_addr = h1_addr;
    wr_data = up_ent;
    case (step_r)
      2'd0: begin
        wr_addr = h1_addr;
        wr_data = up_ent;
      end
      2'd1: begin
        wr_addr = (hit_lvl == LVL_TWO) ? fpos_r[1] : vpos_r[1];
        wr_data = vent_r[0];
      end
      default: begin
        wr_addr = s3_addr;
        wr_data = vent_r[1];
      end
    endcase

    res_nxt.hit_level       = hit_lvl;
    res_nxt.level_one_slot  = 3'(h1_addr);
    res_nxt.access_cost     = cost_r[hit_lvl];
    res_nxt.writeback_valid = (hit_lvl == LVL_MEM) && vent_r[2].valid && vent_r[2].dirty;
    res_nxt.writeback_block = res_nxt.writeback_valid ? vent_r[2].blk : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r[0] <= CostW'(10);
      cost_r[1] <= CostW'(110);
      cost_r[2] <= CostW'(1110);
      cost_r[3] <= CostW'(101110);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_COST_L1:  cost_r[0] <= cfg_data;
        CFG_COST_L2:  cost_r[1] <= cfg_data;
        CFG_COST_L3:  cost_r[2] <= cfg_data;
        CFG_COST_MEM: cost_r[3] <= cfg_data;
        default:      cost_r[0] <= cost_r[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clk_cnt_r   <= '0;
      rd_cnt_r    <= '0;
      chk_vld_r   <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        found_r[i] <= 1'b0;
        vinv_r[i]  <= 1'b0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      chk_vld_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            clk_cnt_r <= clk_cnt_r + 1'b1;
            rd_cnt_r  <= '0;
            for (int i = 0; i < 3; i++) begin
              found_r[i] <= 1'b0;
              vinv_r[i]  <= 1'b0;
            end
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_cnt_r < (AW+1)'(Depth)) begin
            rd_cnt_r  <= rd_cnt_r + 1'b1;
            chk_vld_r <= 1'b1;
          end
          if (chk_vld_r) begin
            if (match && !found_r[lv]) begin
              found_r[lv] <= 1'b1;
            end
            if (take_vic) begin
              vinv_r[lv] <= !rd_data.valid;
            end
            if (chk_addr_r == AW'(Depth - 1)) begin
              step_r  <= '0;
              state_r <= ST_WR;
            end
          end
        end
        ST_WR: begin
          if (step_r == last_step) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_addr_r <= rd_addr;
    if (in_acc) begin
      blk_r <= BlkW'(in_data.block_address % MemBlocks);
      wr_r  <= in_data.is_write;
    end
    if (state_r == ST_SCAN && chk_vld_r) begin
      if (match && !found_r[lv]) begin
        fpos_r[lv] <= chk_addr_r;
        fent_r[lv] <= rd_data;
      end
      if (take_vic) begin
        vpos_r[lv] <= chk_addr_r;
        vent_r[lv] <= rd_data;
      end
    end
    if (state_r == ST_WR && step_r == last_step) begin
      res_r <= res_nxt;
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r <= res_r;
    end
  end

  `TLC_ASSERT_NEXT(a_accept_starts_scan, in_acc, state_r == ST_SCAN)
  `TLC_ASSERT_NOW(a_wb_only_on_miss, out_valid_r && out_data_r.writeback_valid, out_data_r.hit_level == LVL_MEM)
  `TLC_ASSERT_NOW(a_result_after_done, $rose(out_valid_r), $past(state_r == ST_DONE))

endmodule
